@@ hw/rtl/fcpa_pkg.sv @@
// shared types and constants of the fixed chunk pool allocator
// no dependencies; imported by the row search and the top level
`timescale 1ns / 1ps

package fcpa_pkg;

  localparam int unsigned ROW_BITS  = 32;
  localparam int unsigned ROW_OFS_W = 5;
  localparam int unsigned NUM_W     = 10;

  localparam logic [5:0]  LOG2_SIZE_RST   = 6'd16;
  localparam logic [10:0] CHUNK_COUNT_RST = 11'd1024;

  typedef enum logic {
    OP_REQUEST = 1'b0,
    OP_RELEASE = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_EMPTY      = 3'd1,
    ST_BELOW      = 3'd2,
    ST_BEYOND     = 3'd3,
    ST_MISALIGNED = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    REG_POOL_BASE   = 2'd0,
    REG_LOG2_SIZE   = 2'd1,
    REG_CHUNK_COUNT = 2'd2
  } reg_e;

  typedef struct packed {
    logic                 hit;
    logic [ROW_OFS_W-1:0] pos;
    logic                 more;
  } search_t;

  function automatic logic [ROW_OFS_W-1:0] first_set(input logic [ROW_BITS-1:0] v);
    logic [ROW_OFS_W-1:0] r;
    r = '0;
    for (int i = ROW_BITS - 1; i >= 0; i--) begin
      if (v[i]) r = ROW_OFS_W'(i);
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/fixed_chunk_pool_allocator.sv @@
// fixed chunk pool allocator top level: sequencer, bitmap and tag memories
// depends on fcpa_pkg, fcpa_ram, fcpa_row_search
//
// channel   direction  contents (lowest bit first)
// s_axis    in         tdata: bucket_number, is_loaned, borrower, release_address
//                      tuser: opcode
// m_axis    out        tdata: status, chunk_address, chunk_number
// cfg       in         write enable, register index, 64-bit data
//
// a granted request passes through decode, grant and result, plus a scan step for every
// further 32-chunk bitmap row that the next-free scan reads; an empty-pool request goes
// from decode straight to the result; a good release runs address check, bitmap read,
// bitmap write and result, a rejected one skips the bitmap read and write; after reset and
// after a chunk_count write a clearing pass zeroes every bitmap row, with s_axis_tready low
// a result waits in the output register while the next item runs; if it is still held
// when the next result is ready, the sequencer waits and s_axis_tready stays low
`timescale 1ns / 1ps

module fixed_chunk_pool_allocator #(
  parameter int unsigned MAX_CHUNKS = 1024,
  parameter int unsigned TAG_BITS   = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [103:0] s_axis_tdata,   // bucket_number, is_loaned, borrower, release_address
  input  logic         s_axis_tuser,   // opcode
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [79:0]  m_axis_tdata,   // status, chunk_address, chunk_number
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [63:0]  cfg_wdata_i
);
  import fcpa_pkg::*;

  localparam int unsigned IDX_W  = $clog2(MAX_CHUNKS);
  localparam int unsigned CNT_W  = ($clog2(MAX_CHUNKS + 1) > 11) ? $clog2(MAX_CHUNKS + 1) : 11;
  localparam int unsigned ROWS   = (MAX_CHUNKS + ROW_BITS - 1) / ROW_BITS;
  localparam int unsigned ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned XI_W   = ROW_W + ROW_OFS_W;
  localparam int unsigned META_W = 2 * TAG_BITS + 1;

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_DECODE = 8'b0000_0100,
    S_CHECK  = 8'b0000_1000,
    S_GRANT  = 8'b0001_0000,
    S_SCAN   = 8'b0010_0000,
    S_FREE   = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_e;

  function automatic logic [CNT_W-1:0] eff_count(input logic [10:0] c);
    logic [CNT_W-1:0] cx;
    cx = CNT_W'(c);
    return (cx > CNT_W'(MAX_CHUNKS)) ? CNT_W'(MAX_CHUNKS) : cx;
  endfunction

  state_e             state_q, state_d;
  logic [63:0]        base_q, base_d;
  logic [5:0]         shift_q, shift_d;
  logic [10:0]        cnt_q, cnt_d;
  logic [IDX_W-1:0]   next_free_q, next_free_d;
  logic               empty_q, empty_d;
  logic [ROW_W-1:0]   clr_q, clr_d;
  logic [ROW_W-1:0]   scan_row_q, scan_row_d;
  logic               m_valid_q, m_valid_d;

  logic               op_q;
  logic [15:0]        bucket_q;
  logic               loaned_q;
  logic [15:0]        borrower_q;
  logic [63:0]        addr_q;
  logic [IDX_W-1:0]   k_q, k_d;
  logic               below_q, below_d;
  logic [63:0]        off_q, off_d;
  status_e            res_status_q, res_status_d;
  logic [63:0]        res_addr_q, res_addr_d;
  logic [IDX_W-1:0]   res_num_q, res_num_d;
  logic [2:0]         m_status_q;
  logic [63:0]        m_addr_q;
  logic [NUM_W-1:0]   m_num_q;

  logic [CNT_W-1:0]   count;
  logic [XI_W-1:0]    k_x, nf_x;
  logic [ROW_W-1:0]   k_row;
  logic [ROW_OFS_W-1:0] k_bit;
  logic [ROW_BITS-1:0] bit_mask;
  logic [63:0]        rel_idx;
  logic               rel_low;
  logic [IDX_W-1:0]   rel_k;
  logic [XI_W-1:0]    rel_x;
  logic               s_xfer, m_load;

  logic               bm_we;
  logic [ROW_W-1:0]   bm_waddr, bm_raddr;
  logic [ROW_BITS-1:0] bm_wdata, bm_rdata;
  logic               md_we;
  logic [IDX_W-1:0]   md_waddr;
  logic [META_W-1:0]  md_wdata, md_rdata;

  logic [ROW_W-1:0]   srch_row;
  logic [ROW_OFS_W:0] srch_start;
  search_t            srch;

  fcpa_ram #(.WIDTH(ROW_BITS), .DEPTH(ROWS), .AW(ROW_W)) u_bitmap (
    .clk_i,
    .we_i    (bm_we),
    .waddr_i (bm_waddr),
    .wdata_i (bm_wdata),
    .raddr_i (bm_raddr),
    .rdata_o (bm_rdata)
  );

  fcpa_ram #(.WIDTH(META_W), .DEPTH(MAX_CHUNKS), .AW(IDX_W)) u_meta (
    .clk_i,
    .we_i    (md_we),
    .waddr_i (md_waddr),
    .wdata_i (md_wdata),
    .raddr_i (next_free_q),
    .rdata_o (md_rdata)
  );

  fcpa_row_search #(.ROW_W(ROW_W), .CNT_W(CNT_W)) u_search (
    .used_i  (bm_rdata),
    .row_i   (srch_row),
    .start_i (srch_start),
    .count_i (count),
    .res_o   (srch)
  );

  assign count    = eff_count(cnt_q);
  assign k_x      = XI_W'(k_q);
  assign nf_x     = XI_W'(next_free_q);
  assign k_row    = k_x[XI_W-1:ROW_OFS_W];
  assign k_bit    = k_x[ROW_OFS_W-1:0];
  assign bit_mask = ROW_BITS'(1) << k_bit;
  assign rel_idx  = off_q >> shift_q;
  assign rel_low  = |(off_q & ~({64{1'b1}} << shift_q));
  assign rel_k    = rel_idx[IDX_W-1:0];
  assign rel_x    = XI_W'(rel_k);

  assign srch_row   = (state_q == S_GRANT) ? k_row : scan_row_q;
  assign srch_start = (state_q == S_GRANT) ? ((ROW_OFS_W + 1)'(k_bit) + 1'b1) : '0;

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_xfer        = s_axis_tvalid && s_axis_tready;
  assign m_load        = (state_q == S_DONE) && (!m_valid_q || m_axis_tready);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {3'b000, m_num_q, m_addr_q, m_status_q};

  always_comb begin
    state_d      = state_q;
    base_d       = base_q;
    shift_d      = shift_q;
    cnt_d        = cnt_q;
    next_free_d  = next_free_q;
    empty_d      = empty_q;
    clr_d        = clr_q;
    scan_row_d   = scan_row_q;
    m_valid_d    = m_valid_q;
    k_d          = k_q;
    below_d      = below_q;
    off_d        = off_q;
    res_status_d = res_status_q;
    res_addr_d   = res_addr_q;
    res_num_d    = res_num_q;
    bm_we        = 1'b0;
    bm_waddr     = k_row;
    bm_wdata     = '0;
    bm_raddr     = k_row;
    md_we        = 1'b0;
    md_waddr     = k_q;
    md_wdata     = '0;

    if (m_valid_q && m_axis_tready) m_valid_d = 1'b0;

    case (state_q)
      S_CLEAR: begin
        bm_we    = 1'b1;
        bm_waddr = clr_q;
        bm_wdata = '0;
        clr_d    = clr_q + 1'b1;
        if (clr_q == ROW_W'(ROWS - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (s_xfer) state_d = S_DECODE;
      end
      S_DECODE: begin
        if (op_q == OP_REQUEST) begin
          if (empty_q || (CNT_W'(next_free_q) >= count)) begin
            res_status_d = ST_EMPTY;
            res_addr_d   = '0;
            res_num_d    = '0;
            state_d      = S_DONE;
          end else begin
            k_d          = next_free_q;
            bm_raddr     = nf_x[XI_W-1:ROW_OFS_W];
            res_status_d = ST_OK;
            res_addr_d   = base_q + (64'(next_free_q) << shift_q);
            res_num_d    = next_free_q;
            state_d      = S_GRANT;
          end
        end else begin
          below_d = addr_q < base_q;
          off_d   = addr_q - base_q;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        res_addr_d = '0;
        res_num_d  = '0;
        state_d    = S_DONE;
        if (below_q) begin
          res_status_d = ST_BELOW;
        end else if (rel_idx >= 64'(count)) begin
          res_status_d = ST_BEYOND;
        end else if (rel_low) begin
          res_status_d = ST_MISALIGNED;
        end else begin
          k_d          = rel_idx[IDX_W-1:0];
          bm_raddr     = rel_x[XI_W-1:ROW_OFS_W];
          md_we        = 1'b1;
          md_waddr     = rel_idx[IDX_W-1:0];
          md_wdata     = {1'b0, {(2 * TAG_BITS){1'b1}}};
          res_status_d = ST_OK;
          res_num_d    = rel_idx[IDX_W-1:0];
          if (empty_q || (rel_idx[IDX_W-1:0] < next_free_q)) begin
            next_free_d = rel_idx[IDX_W-1:0];
            empty_d     = 1'b0;
          end
          state_d = S_FREE;
        end
      end
      S_FREE: begin
        bm_we    = 1'b1;
        bm_wdata = bm_rdata & ~bit_mask;
        state_d  = S_DONE;
      end
      S_GRANT: begin
        bm_we    = 1'b1;
        bm_wdata = bm_rdata | bit_mask;
        md_we    = 1'b1;
        md_wdata = {loaned_q, TAG_BITS'(bucket_q),
                    loaned_q ? TAG_BITS'(borrower_q) : md_rdata[TAG_BITS-1:0]};
        bm_raddr   = k_row + 1'b1;
        scan_row_d = k_row + 1'b1;
        if (srch.hit) begin
          next_free_d = IDX_W'({k_row, srch.pos});
          empty_d     = 1'b0;
          state_d     = S_DONE;
        end else if (srch.more) begin
          state_d = S_SCAN;
        end else begin
          empty_d = 1'b1;
          state_d = S_DONE;
        end
      end
      S_SCAN: begin
        bm_raddr   = scan_row_q + 1'b1;
        scan_row_d = scan_row_q + 1'b1;
        if (srch.hit) begin
          next_free_d = IDX_W'({scan_row_q, srch.pos});
          empty_d     = 1'b0;
          state_d     = S_DONE;
        end else if (!srch.more) begin
          empty_d = 1'b1;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (m_load) begin
          m_valid_d = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_POOL_BASE: base_d  = cfg_wdata_i;
        REG_LOG2_SIZE: shift_d = cfg_wdata_i[5:0];
        REG_CHUNK_COUNT: begin
          cnt_d       = cfg_wdata_i[10:0];
          next_free_d = '0;
          empty_d     = (eff_count(cfg_wdata_i[10:0]) == '0);
          clr_d       = '0;
          state_d     = S_CLEAR;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      base_q      <= '0;
      shift_q     <= LOG2_SIZE_RST;
      cnt_q       <= CHUNK_COUNT_RST;
      next_free_q <= '0;
      empty_q     <= (eff_count(CHUNK_COUNT_RST) == '0);
      clr_q       <= '0;
      scan_row_q  <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      base_q      <= base_d;
      shift_q     <= shift_d;
      cnt_q       <= cnt_d;
      next_free_q <= next_free_d;
      empty_q     <= empty_d;
      clr_q       <= clr_d;
      scan_row_q  <= scan_row_d;
      m_valid_q   <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      op_q       <= s_axis_tuser;
      bucket_q   <= s_axis_tdata[15:0];
      loaned_q   <= s_axis_tdata[16];
      borrower_q <= s_axis_tdata[32:17];
      addr_q     <= s_axis_tdata[96:33];
    end
    k_q          <= k_d;
    below_q      <= below_d;
    off_q        <= off_d;
    res_status_q <= res_status_d;
    res_addr_q   <= res_addr_d;
    res_num_q    <= res_num_d;
    if (m_load) begin
      m_status_q <= res_status_q;
      m_addr_q   <= res_addr_q;
      m_num_q    <= NUM_W'(res_num_q);
    end
  end

endmodule

@@ hw/rtl/fcpa_ram.sv @@
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
`timescale 1ns / 1ps

module fcpa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/fcpa_row_search.sv @@
// finds the lowest free chunk in one row of the in-use bitmap
// depends on fcpa_pkg
`timescale 1ns / 1ps

module fcpa_row_search #(
  parameter int unsigned ROW_W = 5,
  parameter int unsigned CNT_W = 11
) (
  input  logic [fcpa_pkg::ROW_BITS-1:0] used_i,
  input  logic [ROW_W-1:0]              row_i,
  input  logic [fcpa_pkg::ROW_OFS_W:0]  start_i,
  input  logic [CNT_W-1:0]              count_i,
  output fcpa_pkg::search_t             res_o
);
  import fcpa_pkg::*;

  localparam int unsigned XI_W  = ROW_W + ROW_OFS_W;
  localparam int unsigned CMP_W = ((CNT_W > XI_W) ? CNT_W : XI_W) + 1;

  logic [CMP_W-1:0]    base;
  logic [CMP_W-1:0]    cnt;
  logic [CMP_W-1:0]    rem;
  logic [ROW_BITS-1:0] cand;

  always_comb begin
    base = CMP_W'({row_i, {ROW_OFS_W{1'b0}}});
    cnt  = CMP_W'(count_i);
    rem  = (cnt > base) ? (cnt - base) : '0;
    for (int p = 0; p < ROW_BITS; p++) begin
      cand[p] = !used_i[p] && (rem > CMP_W'(p)) && (start_i <= (ROW_OFS_W + 1)'(p));
    end
    res_o.hit  = |cand;
    res_o.pos  = first_set(cand);
    res_o.more = (base + CMP_W'(ROW_BITS)) < cnt;
  end

endmodule
